// ===== rtl/pts_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// pts_pkg: shared types and constants of the priority task scheduler.
// Holds the slot count, derived widths, action and slot state codes, and the
// packed item types of the request and result channels.
// ============================================================================
package pts_pkg;

    // Number of task slots; slot 0 is the idle task.
    localparam int NUM_SLOTS  = 8;
    localparam int SLOT_W     = $clog2(NUM_SLOTS);
    // Scan counter width, able to hold NUM_SLOTS itself.
    localparam int CNT_W      = SLOT_W + 1;
    // Fixed width of the slot fields on the result channel.
    localparam int OUT_SLOT_W = 3;

    // Action codes.
    localparam logic [2:0] ACT_CREATE = 3'd0;
    localparam logic [2:0] ACT_DELETE = 3'd1;
    localparam logic [2:0] ACT_DELAY  = 3'd2;
    localparam logic [2:0] ACT_END    = 3'd3;
    localparam logic [2:0] ACT_SELECT = 3'd4;

    // Slot state codes.
    localparam logic [1:0] ST_FREE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_SLEEP = 2'd2;

    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] handle;
        logic [7:0]  priority_req;
        logic [31:0] duration_ms;
        logic [31:0] now_ms;
    } sched_in_t;

    typedef struct packed {
        logic                  ok;
        logic [OUT_SLOT_W-1:0] slot;
        logic                  switch_request;
        logic [OUT_SLOT_W-1:0] current_task;
    } sched_out_t;

endpackage

// ===== rtl/priority_task_scheduler.sv =====
`timescale 1ns / 1ps
// ============================================================================
// priority_task_scheduler: task table with priority selection and sleep timers.
// One request item in, one result item out. A small sequencer walks the slots
// one per cycle through a shared compare and elapsed-time unit.
// ============================================================================
// Usage:
//   Requests arrive on in_item with in_valid; an item is taken at an edge with
//   in_valid high and in_stall low. in_stall stays high while an item is in
//   work. Results leave on out_item with out_valid; the receiver holds
//   out_stall high to keep a result in the output register.
//   Create, delete and select walk slots 1 to NUM_SLOTS-1 at one slot per
//   cycle through the handle and timer memories (registered read), then pass
//   the final step that loads the output register. Delay, end and unused
//   codes take the execute step and then the final step. One item is in
//   work at a time; a new item may be accepted while the previous result
//   still waits in the output register, and the next result waits in its
//   final step until that register is free.
//   The protected handle is written on cfg_data with cfg_valid; cfg_ready is
//   always high. Reset marks every slot free except the running idle slot 0,
//   clears priorities, the current slot and the protected handle.
// ============================================================================
module priority_task_scheduler (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  pts_pkg::sched_in_t in_item,
    output logic               out_valid,
    input  logic               out_stall,
    output pts_pkg::sched_out_t out_item,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [31:0]        cfg_data
);
    import pts_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_EXEC   = 2'd1;
    localparam logic [1:0] S_SCAN   = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    logic [1:0]        state_reg;
    sched_in_t         act_reg;
    logic [31:0]       prot_reg;
    logic [SLOT_W-1:0] cur_reg;
    logic [CNT_W-1:0]  idx_reg;
    logic              proc_valid_reg;
    logic [SLOT_W-1:0] proc_idx_reg;
    logic              res_ok_reg;
    logic [SLOT_W-1:0] res_slot_reg;
    logic              res_sw_reg;
    logic [SLOT_W-1:0] best_reg;
    logic [7:0]        best_prio_reg;
    logic              found_reg;
    logic              out_valid_reg;
    sched_out_t        out_item_reg;

    logic [1:0]        status_reg [NUM_SLOTS];
    logic [7:0]        prio_reg   [NUM_SLOTS];

    logic [31:0]       handle_mem [NUM_SLOTS];
    logic [31:0]       start_mem  [NUM_SLOTS];
    logic [31:0]       length_mem [NUM_SLOTS];
    logic [31:0]       rd_handle_reg;
    logic [31:0]       rd_start_reg;
    logic [31:0]       rd_length_reg;

    logic              accept;
    logic              out_free;
    logic [SLOT_W-1:0] rd_addr;
    logic [SLOT_W-1:0] stat_addr;
    logic [1:0]        stat_rd;
    logic [7:0]        prio_rd;
    logic [31:0]       elapsed;
    logic              woke;
    logic              slot_ready;
    logic              take;
    logic              claim;
    logic              kill;
    logic              wake;
    logic              last;
    logic              delay_set;
    logic              end_free;
    logic              st_we;
    logic [1:0]        st_wdata;
    logic [SLOT_W-1:0] sel_best;
    logic              sel_found;

    // Channel handshakes.
    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // Shared slot read port and per-slot decisions.
    assign rd_addr    = idx_reg[SLOT_W-1:0];
    assign stat_addr  = (state_reg == S_EXEC) ? cur_reg : proc_idx_reg;
    assign stat_rd    = status_reg[stat_addr];
    assign prio_rd    = prio_reg[proc_idx_reg];
    assign elapsed    = act_reg.now_ms - rd_start_reg;
    assign woke       = (stat_rd == ST_SLEEP) && (elapsed >= rd_length_reg);
    assign slot_ready = (stat_rd == ST_RUN) || woke;
    assign take       = slot_ready && (prio_rd >= best_prio_reg);

    assign claim = proc_valid_reg && (act_reg.action == ACT_CREATE) && !res_ok_reg
                   && (stat_rd == ST_FREE);
    assign kill  = proc_valid_reg && (act_reg.action == ACT_DELETE)
                   && (act_reg.handle != prot_reg) && (stat_rd != ST_FREE)
                   && (rd_handle_reg == act_reg.handle);
    assign wake  = proc_valid_reg && (act_reg.action == ACT_SELECT) && woke;
    assign last  = proc_valid_reg && (proc_idx_reg == SLOT_W'(NUM_SLOTS - 1));

    assign delay_set = (state_reg == S_EXEC) && (act_reg.action == ACT_DELAY)
                       && (stat_rd != ST_SLEEP);
    assign end_free  = (state_reg == S_EXEC) && (act_reg.action == ACT_END)
                       && (cur_reg != '0);

    assign sel_best  = take ? proc_idx_reg : best_reg;
    assign sel_found = take || found_reg;

    // Single write port of the slot state table.
    always_comb
    begin
        st_we    = 1'b0;
        st_wdata = ST_FREE;
        if (claim || wake)
        begin
            st_we    = 1'b1;
            st_wdata = ST_RUN;
        end
        else if (kill || end_free)
        begin
            st_we    = 1'b1;
            st_wdata = ST_FREE;
        end
        else if (delay_set)
        begin
            st_we    = 1'b1;
            st_wdata = ST_SLEEP;
        end
    end

    // Slot state and priority tables.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                status_reg[i] <= ST_FREE;
                prio_reg[i]   <= 8'd0;
            end
            status_reg[0] <= ST_RUN;
        end
        else
        begin
            if (st_we)
            begin
                status_reg[stat_addr] <= st_wdata;
            end
            if (claim)
            begin
                prio_reg[proc_idx_reg] <= act_reg.priority_req;
            end
        end
    end

    // Handle and sleep timer memories with registered reads.
    always_ff @(posedge clk)
    begin
        if (claim)
        begin
            handle_mem[proc_idx_reg] <= act_reg.handle;
        end
        rd_handle_reg <= handle_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (delay_set)
        begin
            start_mem[cur_reg]  <= act_reg.now_ms;
            length_mem[cur_reg] <= act_reg.duration_ms;
        end
        rd_start_reg  <= start_mem[rd_addr];
        rd_length_reg <= length_mem[rd_addr];
    end

    // Protected handle register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prot_reg <= 32'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            prot_reg <= cfg_data;
        end
    end

    // Request item latch.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg <= in_item;
        end
    end

    // Sequencer, scan bookkeeping and result assembly.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cur_reg        <= '0;
            idx_reg        <= '0;
            proc_valid_reg <= 1'b0;
            proc_idx_reg   <= '0;
            res_ok_reg     <= 1'b0;
            res_slot_reg   <= '0;
            res_sw_reg     <= 1'b0;
            best_reg       <= '0;
            best_prio_reg  <= 8'd0;
            found_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_item_reg   <= '0;
        end
        else
        begin
            if (out_valid_reg && !out_stall && (state_reg != S_FINISH))
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        res_ok_reg     <= (in_item.action != ACT_CREATE);
                        res_slot_reg   <= '0;
                        res_sw_reg     <= 1'b0;
                        best_reg       <= '0;
                        best_prio_reg  <= 8'd0;
                        found_reg      <= 1'b0;
                        idx_reg        <= CNT_W'(1);
                        proc_valid_reg <= 1'b0;
                        if (in_item.action == ACT_CREATE || in_item.action == ACT_DELETE
                            || in_item.action == ACT_SELECT)
                        begin
                            state_reg <= S_SCAN;
                        end
                        else
                        begin
                            state_reg <= S_EXEC;
                        end
                    end
                end

                S_EXEC:
                begin
                    if (act_reg.action == ACT_DELAY || end_free)
                    begin
                        res_sw_reg <= 1'b1;
                    end
                    state_reg <= S_FINISH;
                end

                S_SCAN:
                begin
                    // Read stage runs one slot ahead of the decision stage; the
                    // decision valid drops by itself once the read index passes
                    // the last slot.
                    proc_valid_reg <= (idx_reg < CNT_W'(NUM_SLOTS));
                    proc_idx_reg   <= idx_reg[SLOT_W-1:0];
                    if (idx_reg < CNT_W'(NUM_SLOTS))
                    begin
                        idx_reg <= idx_reg + CNT_W'(1);
                    end

                    if (claim)
                    begin
                        res_ok_reg   <= 1'b1;
                        res_slot_reg <= proc_idx_reg;
                    end
                    if (kill && (cur_reg == proc_idx_reg))
                    begin
                        res_sw_reg <= 1'b1;
                    end
                    if (proc_valid_reg && act_reg.action == ACT_SELECT && take)
                    begin
                        best_reg      <= proc_idx_reg;
                        best_prio_reg <= prio_rd;
                        found_reg     <= 1'b1;
                    end

                    if (last)
                    begin
                        if (act_reg.action == ACT_SELECT)
                        begin
                            cur_reg      <= sel_found ? sel_best : '0;
                            res_slot_reg <= sel_found ? sel_best : '0;
                        end
                        state_reg <= S_FINISH;
                    end
                end

                S_FINISH:
                begin
                    if (out_free)
                    begin
                        out_valid_reg               <= 1'b1;
                        out_item_reg.ok             <= res_ok_reg;
                        out_item_reg.slot           <= OUT_SLOT_W'(res_slot_reg);
                        out_item_reg.switch_request <= res_sw_reg;
                        out_item_reg.current_task   <= OUT_SLOT_W'(cur_reg);
                        state_reg                   <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // The idle slot is never freed.
    a_idle_never_free: assert property (@(posedge clk) disable iff (!rst_n)
        status_reg[0] != ST_FREE)
        else $error("idle slot became free");

    // A failed create reports no slot and no switch.
    a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_item_reg.ok |-> out_item_reg.slot == '0
                                              && !out_item_reg.switch_request)
        else $error("failed create reported a slot or a switch");

    // The decision stage only runs during a scan.
    a_proc_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        proc_valid_reg |-> state_reg == S_SCAN)
        else $error("slot decision outside scan");

    // A new result only comes from the final step.
    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_FINISH)
        else $error("result loaded outside final step");

endmodule

// ===== sim/tb_priority_task_scheduler.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_priority_task_scheduler: self-checking bench for the task scheduler.
// Drives request items through the valid/stall channel, keeps its own copy of
// the task table to predict every result item, and compares results in
// order. Directed cases cover table fill, ties, sleep wrap-around, protected
// deletes and ending the current task; random phases then vary the idling
// of both channels and the protected handle.
// ============================================================================
module tb_priority_task_scheduler;

    import pts_pkg::*;

    // Quiet cycles allowed before the run is declared hung.
    localparam int QUIET_LIMIT = 2000;
    // Cycles to wait after the last result for any stray output.
    localparam int TAIL_CYCLES = 16;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    sched_in_t   in_item   = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    sched_out_t  out_item;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data  = '0;

    // Shadow copy of the task table.
    logic [1:0]            slot_state [NUM_SLOTS];
    logic [7:0]            slot_pri   [NUM_SLOTS];
    logic [31:0]           slot_hnd   [NUM_SLOTS];
    logic [31:0]           nap_start  [NUM_SLOTS];
    logic [31:0]           nap_len    [NUM_SLOTS];
    logic [OUT_SLOT_W-1:0] cur_slot;
    logic [31:0]           prot_handle;

    // Results owed by the block, oldest first.
    sched_out_t  sched_results_due [$];
    sched_out_t  want;
    int          mismatches  = 0;
    int          results_seen = 0;

    // Random stimulus knobs.
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    logic [31:0] tick_ms     = '0;
    logic [31:0] handle_pool [8];

    priority_task_scheduler u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Receiver stalls at random, one decision per cycle.
    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end

    // Prints one mismatch line and counts it.
    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("mismatch: %s", msg);
    endtask

    // Puts the shadow table into its post-reset state.
    function automatic void clear_table();
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            slot_state[i] = ST_FREE;
            slot_pri[i]   = '0;
            slot_hnd[i]   = '0;
            nap_start[i]  = '0;
            nap_len[i]    = '0;
        end
        slot_state[0] = ST_RUN;
        cur_slot      = '0;
        prot_handle   = '0;
    endfunction

    // Applies one request to the shadow table and returns the result it owes.
    function automatic sched_out_t apply_request(input sched_in_t req);
        sched_out_t  res;
        int          cur;
        int          best;
        logic [7:0]  best_pri;
        logic [31:0] elapsed;
        bit          ready;
        bit          done;
        res.ok             = 1'b1;
        res.slot           = '0;
        res.switch_request = 1'b0;
        cur      = int'(cur_slot);
        best     = 0;
        best_pri = '0;
        done     = 1'b0;
        case (req.action)
            ACT_CREATE:
            begin
                res.ok = 1'b0;
                for (int i = 1; i < NUM_SLOTS; i++)
                begin
                    if (!done && slot_state[i] == ST_FREE)
                    begin
                        slot_state[i] = ST_RUN;
                        slot_hnd[i]   = req.handle;
                        slot_pri[i]   = req.priority_req;
                        res.ok        = 1'b1;
                        res.slot      = OUT_SLOT_W'(i);
                        done          = 1'b1;
                    end
                end
            end
            ACT_DELETE:
            begin
                if (req.handle != prot_handle)
                begin
                    for (int i = 1; i < NUM_SLOTS; i++)
                    begin
                        if (slot_state[i] != ST_FREE && slot_hnd[i] == req.handle)
                        begin
                            slot_state[i] = ST_FREE;
                            if (cur == i)
                                res.switch_request = 1'b1;
                        end
                    end
                end
            end
            ACT_DELAY:
            begin
                // A sleeper keeps its original start time and length.
                if (slot_state[cur] != ST_SLEEP)
                begin
                    slot_state[cur] = ST_SLEEP;
                    nap_start[cur]  = req.now_ms;
                    nap_len[cur]    = req.duration_ms;
                end
                res.switch_request = 1'b1;
            end
            ACT_END:
            begin
                if (cur != 0)
                begin
                    slot_state[cur]    = ST_FREE;
                    res.switch_request = 1'b1;
                end
            end
            ACT_SELECT:
            begin
                // Wake expired sleepers; the highest priority wins, later slot on a tie.
                for (int i = 1; i < NUM_SLOTS; i++)
                begin
                    ready   = (slot_state[i] == ST_RUN);
                    elapsed = req.now_ms - nap_start[i];
                    if (slot_state[i] == ST_SLEEP && elapsed >= nap_len[i])
                    begin
                        slot_state[i] = ST_RUN;
                        ready         = 1'b1;
                    end
                    if (ready && slot_pri[i] >= best_pri)
                    begin
                        best_pri = slot_pri[i];
                        best     = i;
                    end
                end
                cur_slot = OUT_SLOT_W'(best);
                res.slot = cur_slot;
            end
            default: ;
        endcase
        res.current_task = cur_slot;
        return res;
    endfunction

    // Checks accepted results, tracks register writes and predicts accepted items.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (sched_results_due.size() == 0)
                    report_mismatch($sformatf("result %0d arrived with none owed",
                                              results_seen));
                else
                begin
                    want = sched_results_due.pop_front();
                    if (out_item.ok !== want.ok)
                        report_mismatch($sformatf("result %0d ok %b, predicted %b",
                                                  results_seen, out_item.ok, want.ok));
                    if (out_item.slot !== want.slot)
                        report_mismatch($sformatf("result %0d slot %0d, predicted %0d",
                                                  results_seen, out_item.slot, want.slot));
                    if (out_item.switch_request !== want.switch_request)
                        report_mismatch($sformatf("result %0d switch %b, predicted %b",
                                                  results_seen, out_item.switch_request,
                                                  want.switch_request));
                    if (out_item.current_task !== want.current_task)
                        report_mismatch($sformatf("result %0d current %0d, predicted %0d",
                                                  results_seen, out_item.current_task,
                                                  want.current_task));
                end
            end
            if (cfg_valid && cfg_ready)
                prot_handle = cfg_data;
            if (in_valid && !in_stall)
                sched_results_due.push_back(apply_request(in_item));
        end
    end

    // Ends the run if no channel moves anything for too long.
    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall) ||
                (cfg_valid && cfg_ready === 1'b1))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT)
                break;
        end
        $display("tb_priority_task_scheduler: FAIL");
        $finish;
    end

    // Sends one request item, after a random idle gap, and waits for acceptance.
    task automatic send_item(input sched_in_t req);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < tx_idle_pct)
            gap++;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= req;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
    endtask

    // Lowers valid and waits until every owed result has been taken.
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sched_results_due.size() != 0)
            @(posedge clk);
    endtask

    // Writes the protected handle; only called while the block is idle.
    task automatic write_protected(input logic [31:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic sched_in_t make_req(input logic [2:0] action, input logic [31:0] hnd,
                                           input logic [7:0] pri, input logic [31:0] dur,
                                           input logic [31:0] now);
        sched_in_t req;
        req.action       = action;
        req.handle       = hnd;
        req.priority_req = pri;
        req.duration_ms  = dur;
        req.now_ms       = now;
        return req;
    endfunction

    // Builds one random request, steered by the shadow table so deletes hit.
    function automatic sched_in_t random_request();
        sched_in_t req;
        int        r;
        int        pick;
        req.handle       = $urandom;
        req.duration_ms  = $urandom;
        // Millisecond clock mostly creeps forward, sometimes jumps.
        if ($urandom_range(0, 99) < 3)
            tick_ms = $urandom;
        else
            tick_ms = tick_ms + $urandom_range(0, 30);
        req.now_ms = tick_ms;
        r = $urandom_range(0, 99);
        if (r < 50)
            req.priority_req = 8'($urandom_range(0, 255));
        else if (r < 80)
            req.priority_req = 8'($urandom_range(0, 3));
        else if (r < 90)
            req.priority_req = 8'h00;
        else
            req.priority_req = 8'hFF;
        r = $urandom_range(0, 99);
        if (r < 24)
        begin
            req.action = ACT_CREATE;
            if ($urandom_range(0, 99) < 85)
                req.handle = handle_pool[$urandom_range(0, 7)];
        end
        else if (r < 38)
        begin
            req.action = ACT_DELETE;
            r = $urandom_range(0, 99);
            pick = $urandom_range(1, NUM_SLOTS - 1);
            if (r < 45)
                req.handle = (slot_state[pick] != ST_FREE) ? slot_hnd[pick]
                                                           : handle_pool[$urandom_range(0, 7)];
            else if (r < 55)
                req.handle = prot_handle;
            else if (r < 90)
                req.handle = handle_pool[$urandom_range(0, 7)];
        end
        else if (r < 54)
        begin
            req.action = ACT_DELAY;
            r = $urandom_range(0, 99);
            if (r < 15)
                req.duration_ms = '0;
            else if (r < 65)
                req.duration_ms = $urandom_range(1, 40);
            else if (r < 80)
                req.duration_ms = $urandom_range(41, 3000);
            else if (r >= 95)
                req.duration_ms = 32'hFFFF_FFFF;
        end
        else if (r < 64)
            req.action = ACT_END;
        else if (r < 96)
            req.action = ACT_SELECT;
        else
            req.action = 3'($urandom_range(5, 7));
        return req;
    endfunction

    // Ending the idle task and the unused action codes change nothing.
    task automatic test_idle_end();
        send_item(make_req(ACT_END, 32'h0000_0001, 8'd1, 32'd1, 32'd0));
        send_item(make_req(3'd5, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_item(make_req(3'd7, 32'h0, 8'h0, 32'h0, 32'h0));
        wait_drained();
    endtask

    // Fill every slot, then one create with no free slot left.
    task automatic test_create_fill();
        send_item(make_req(ACT_CREATE, 32'h0000_0000, 8'd0,   32'd0, 32'd0));
        send_item(make_req(ACT_CREATE, 32'hFFFF_FFFF, 8'd255, 32'd0, 32'd0));
        send_item(make_req(ACT_CREATE, 32'h0000_1234, 8'd10,  32'd0, 32'd0));
        send_item(make_req(ACT_CREATE, 32'h0000_1234, 8'd255, 32'd0, 32'd0));
        send_item(make_req(ACT_CREATE, 32'h55AA_55AA, 8'd10,  32'd0, 32'd0));
        send_item(make_req(ACT_CREATE, 32'hAAAA_5555, 8'd3,   32'd0, 32'd0));
        send_item(make_req(ACT_CREATE, 32'h7FFF_FFFF, 8'd0,   32'd0, 32'd0));
        send_item(make_req(ACT_CREATE, 32'hDEAD_BEEF, 8'd200, 32'd0, 32'd0));
        wait_drained();
    endtask

    // Priority ties, sleeping, a repeated delay and wake-up across the wrap.
    task automatic test_select_and_delay();
        send_item(make_req(ACT_SELECT, 32'h0, 8'd0, 32'd0,   32'd0));
        send_item(make_req(ACT_DELAY,  32'h0, 8'd0, 32'd100, 32'd1000));
        send_item(make_req(ACT_SELECT, 32'h0, 8'd0, 32'd0,   32'd1050));
        send_item(make_req(ACT_DELAY,  32'h0, 8'd0, 32'd0,   32'hFFFF_FFF0));
        send_item(make_req(ACT_DELAY,  32'h0, 8'd0, 32'd5,   32'd0));
        send_item(make_req(ACT_SELECT, 32'h0, 8'd0, 32'd0,   32'd5));
        wait_drained();
    endtask

    // Protected delete, delete of the current task, empty delete, end and delay of a freed slot.
    task automatic test_delete_and_end();
        send_item(make_req(ACT_DELETE, 32'hFFFF_FFFF, 8'd0, 32'd0,  32'd6));
        send_item(make_req(ACT_DELETE, 32'h0000_1234, 8'd0, 32'd0,  32'd7));
        send_item(make_req(ACT_DELETE, 32'hDEAD_BEEF, 8'd0, 32'd0,  32'd8));
        send_item(make_req(ACT_END,    32'h0,         8'd0, 32'd0,  32'd9));
        send_item(make_req(ACT_DELAY,  32'h0,         8'd0, 32'd20, 32'd10));
        send_item(make_req(ACT_SELECT, 32'h0,         8'd0, 32'd0,  32'd20));
        send_item(make_req(ACT_DELETE, 32'h0000_0000, 8'd0, 32'd0,  32'd21));
        wait_drained();
    endtask

    // Random phase with the given idling; unused action codes are not counted.
    task automatic test_random(input int count, input int tx_pct, input int rx_pct);
        int        sent;
        sched_in_t req;
        tx_idle_pct    = tx_pct;
        rx_idle_pct    = rx_pct;
        handle_pool[0] = 32'h0000_0000;
        handle_pool[1] = 32'hFFFF_FFFF;
        handle_pool[2] = prot_handle;
        for (int i = 3; i < 8; i++)
            handle_pool[i] = $urandom;
        // Start near the top so the millisecond clock wraps within the phase.
        tick_ms = 32'hFFFF_FF00 - $urandom_range(0, 4000);
        sent = 0;
        while (sent < count)
        begin
            req = random_request();
            send_item(req);
            if (req.action <= ACT_SELECT)
                sent++;
        end
        wait_drained();
    endtask

    // Test sequence.
    initial
    begin
        clear_table();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        tx_idle_pct = 16;
        rx_idle_pct = 50;
        write_protected(32'hFFFF_FFFF);
        test_idle_end();
        test_create_fill();
        test_select_and_delay();
        test_delete_and_end();
        write_protected(32'h0000_0000);
        test_random(520, 16, 50);
        write_protected($urandom);
        test_random(520, 50, 16);
        write_protected(32'hFFFF_FFFF);
        test_random(510, 0, 0);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sched_results_due.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", sched_results_due.size()));
        if (mismatches == 0)
            $display("tb_priority_task_scheduler: PASS");
        else
            $display("tb_priority_task_scheduler: FAIL");
        $finish;
    end

endmodule
